// ----- design/orlo_pkg.sv -----
// orlo_pkg: shared constants, register map and helper for the occupancy ray log-odds block
// no dependencies; imported by orlo_alu and occupancy_ray_log_odds_update

package orlo_pkg;

   // default geometry and cell word size
   localparam int GRID_W_DEFAULT    = 256;
   localparam int GRID_H_DEFAULT    = 256;
   localparam int CELL_BITS_DEFAULT = 16;

   // field widths
   localparam int COORD_W     = 8;
   localparam int COUNT_W     = 9;
   localparam int OUT_WORD_W  = 16;
   localparam int FREE_W      = 11;
   localparam int OCC_W       = 11;
   localparam int LMIN_W      = 16;
   localparam int LMAX_W      = 15;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int ERR_W       = 11;

   // register reset values
   localparam logic signed [FREE_W-1:0] FREE_STEP_RESET     = -11'sd1;
   localparam logic [OCC_W-1:0]         OCCUPIED_STEP_RESET = 11'd3;
   localparam logic signed [LMIN_W-1:0] LEVEL_MIN_RESET     = -16'sd512;
   localparam logic [LMAX_W-1:0]        LEVEL_MAX_RESET     = 15'd512;

   // register map, word index
   typedef enum logic [1:0] {
      REG_FREE_STEP     = 2'd0,
      REG_OCCUPIED_STEP = 2'd1,
      REG_LEVEL_MIN     = 2'd2,
      REG_LEVEL_MAX     = 2'd3
   } reg_index_type;

   // width of the shared adder: room for a cell word or a 16 bit bound, plus two bits for carry
   function automatic int sum_width(input int cell_bits);
      int w;
      w = (cell_bits > LMIN_W) ? cell_bits : LMIN_W;
      return w + 2;
   endfunction

endpackage

// ----- design/orlo_alu.sv -----
// orlo_alu: shared cell adder with saturation and bound compares
// depends on orlo_pkg (sum_width)

module orlo_alu
   import orlo_pkg::*;
#(
   parameter int CELL_BITS = CELL_BITS_DEFAULT
) (
   input  logic signed [CELL_BITS-1:0]            operand,
   input  logic signed [sum_width(CELL_BITS)-1:0] step,
   input  logic signed [sum_width(CELL_BITS)-1:0] bound,
   output logic signed [CELL_BITS-1:0]            sum_sat,
   output logic signed [CELL_BITS-1:0]            sum_wrap,
   output logic                                   ge_bound,
   output logic                                   le_bound
);

   localparam int SUM_W = sum_width(CELL_BITS);
   localparam logic signed [SUM_W-1:0] CELL_MAX =
      SUM_W'((64'sd1 <<< (CELL_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] CELL_MIN = -CELL_MAX - SUM_W'(1);

   logic signed [SUM_W-1:0] sum;

   assign sum      = SUM_W'(operand) + step;
   assign ge_bound = (sum >= bound);
   assign le_bound = (sum <= bound);
   assign sum_wrap = CELL_BITS'(sum);

   always_comb begin
      if (sum > CELL_MAX) begin
         sum_sat = CELL_BITS'(CELL_MAX);
      end else if (sum < CELL_MIN) begin
         sum_sat = CELL_BITS'(CELL_MIN);
      end else begin
         sum_sat = CELL_BITS'(sum);
      end
   end

endmodule

// ----- design/occupancy_ray_log_odds_update.sv -----
// occupancy_ray_log_odds_update: occupancy grid with Bresenham ray walk and log-odds update
// depends on orlo_pkg and orlo_alu
//
//   channel   ports                         direction   handshake
//   request   start, busy, req_*            in          beat taken when start & !busy
//   response  rsp_strobe, rsp_*             out         one-cycle strobe, no back-pressure
//   config    psel/penable/pwrite/paddr...  in          apb write on access phase, pready tied high
//
// a write ray of n cells takes a setup step, then per cell the address and read state,
// the level update state and the log-odds update and write state; n = max(|dx|,|dy|)+1, up to 256
// a read beat goes through the address state and the registered memory read
// the per-cell steps follow from the one grid memory and the one shared cell adder
// after reset the grid is swept to zero, one cell a cycle, with busy high
// results are strobed for one cycle; the next beat can be taken in that same cycle

module occupancy_ray_log_odds_update
   import orlo_pkg::*;
#(
   parameter int GRID_W    = GRID_W_DEFAULT,
   parameter int GRID_H    = GRID_H_DEFAULT,
   parameter int CELL_BITS = CELL_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [COORD_W-1:0]            req_start_x,
   input  logic [COORD_W-1:0]            req_start_y,
   input  logic [COORD_W-1:0]            req_end_x,
   input  logic [COORD_W-1:0]            req_end_y,
   // response channel
   output logic                          rsp_strobe,
   output logic signed [OUT_WORD_W-1:0]  rsp_cell_level,
   output logic signed [OUT_WORD_W-1:0]  rsp_cell_log_odds,
   output logic [COUNT_W-1:0]            rsp_cells_walked,
   // config port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   localparam int CELLS  = GRID_W * GRID_H;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SUM_W  = sum_width(CELL_BITS);
   localparam int WORD_W = 2 * CELL_BITS;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SETUP = 6'b000100,
      S_ADDR  = 6'b001000,
      S_LVL   = 6'b010000,
      S_ODD   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic signed [FREE_W-1:0] free_step_ff,     free_step_in;
   logic [OCC_W-1:0]         occupied_step_ff, occupied_step_in;
   logic signed [LMIN_W-1:0] level_min_ff,     level_min_in;
   logic [LMAX_W-1:0]        level_max_ff,     level_max_in;

   // ray walk state
   logic                     op_read_ff, op_read_in;
   logic [COORD_W-1:0]       x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0]       x1_ff, x1_in, y1_ff, y1_in;
   logic [COORD_W-1:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic                     sx_ff, sx_in, sy_ff, sy_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic                     in_grid_ff, in_grid_in;
   logic                     upd_ff, upd_in;
   logic signed [CELL_BITS-1:0] level_new_ff, level_new_in;
   logic [ADDR_W-1:0]        clear_cnt_ff, clear_cnt_in;

   // response registers
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic signed [OUT_WORD_W-1:0]  rsp_level_ff, rsp_level_in;
   logic signed [OUT_WORD_W-1:0]  rsp_odds_ff, rsp_odds_in;
   logic [COUNT_W-1:0]            rsp_count_ff, rsp_count_in;

   // grid memory: level in the upper half, log-odds in the lower half
   logic [WORD_W-1:0]        grid_mem [CELLS];
   logic [WORD_W-1:0]        rd_data_ff;
   logic                     mem_we, mem_re;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [WORD_W-1:0]        mem_wdata;

   logic signed [CELL_BITS-1:0] rd_level, rd_odds;
   logic                     accept, cfg_write, is_end;
   logic                     step_x, step_y;
   logic signed [ERR_W-1:0]  dx_s, dy_s;

   // shared adder
   logic signed [CELL_BITS-1:0] alu_operand, alu_sat, alu_wrap;
   logic signed [SUM_W-1:0]     alu_step, alu_bound;
   logic                        alu_ge, alu_le;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign pready     = 1'b1;
   assign cfg_write  = psel && penable && pwrite && pready;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_cell_level    = rsp_level_ff;
   assign rsp_cell_log_odds = rsp_odds_ff;
   assign rsp_cells_walked  = rsp_count_ff;

   assign rd_level = rd_data_ff[WORD_W-1:CELL_BITS];
   assign rd_odds  = rd_data_ff[CELL_BITS-1:0];
   assign is_end   = (x_ff == x1_ff) && (y_ff == y1_ff);
   assign dx_s     = $signed(ERR_W'(dx_ff));
   assign dy_s     = $signed(ERR_W'(dy_ff));
   // bresenham moves, both decided from the old error term
   assign step_x   = (err_ff > -dx_s);
   assign step_y   = (err_ff < dy_s);

   // end cell takes the occupied step against level_max, others the free step against level_min
   always_comb begin
      alu_operand = (state_ff == S_ODD) ? rd_odds : rd_level;
      if (is_end) begin
         alu_step  = SUM_W'($signed({1'b0, occupied_step_ff}));
         alu_bound = SUM_W'($signed({1'b0, level_max_ff}));
      end else begin
         alu_step  = SUM_W'(free_step_ff);
         alu_bound = SUM_W'(level_min_ff);
      end
   end

   orlo_alu #(
      .CELL_BITS (CELL_BITS)
   ) u_alu (
      .operand  (alu_operand),
      .step     (alu_step),
      .bound    (alu_bound),
      .sum_sat  (alu_sat),
      .sum_wrap (alu_wrap),
      .ge_bound (alu_ge),
      .le_bound (alu_le)
   );

   // config register writes and reads
   always_comb begin
      free_step_in     = free_step_ff;
      occupied_step_in = occupied_step_ff;
      level_min_in     = level_min_ff;
      level_max_in     = level_max_ff;
      if (cfg_write) begin
         case (reg_index_type'(paddr[3:2]))
            REG_FREE_STEP:     free_step_in     = pwdata[FREE_W-1:0];
            REG_OCCUPIED_STEP: occupied_step_in = pwdata[OCC_W-1:0];
            REG_LEVEL_MIN:     level_min_in     = pwdata[LMIN_W-1:0];
            REG_LEVEL_MAX:     level_max_in     = pwdata[LMAX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_FREE_STEP:     prdata = CSR_DATA_W'(free_step_ff);
         REG_OCCUPIED_STEP: prdata = CSR_DATA_W'(occupied_step_ff);
         REG_LEVEL_MIN:     prdata = CSR_DATA_W'(level_min_ff);
         REG_LEVEL_MAX:     prdata = CSR_DATA_W'(level_max_ff);
         default:           prdata = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_read_in    = op_read_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      err_in        = err_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      in_grid_in    = in_grid_ff;
      upd_in        = upd_ff;
      level_new_in  = level_new_ff;
      clear_cnt_in  = clear_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_level_in  = rsp_level_ff;
      rsp_odds_in   = rsp_odds_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = {level_new_ff, alu_sat};

      case (state_ff)
         S_CLEAR: begin
            // zero sweep after reset
            mem_we       = 1'b1;
            mem_waddr    = clear_cnt_ff;
            mem_wdata    = '0;
            clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
            if (clear_cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_read_in = req_opcode;
               x_in       = req_start_x;
               y_in       = req_start_y;
               x1_in      = req_end_x;
               y1_in      = req_end_y;
               state_in   = req_opcode ? S_ADDR : S_SETUP;
            end
         end
         S_SETUP: begin
            dx_in    = (x1_ff > x_ff) ? x1_ff - x_ff : x_ff - x1_ff;
            dy_in    = (y1_ff > y_ff) ? y1_ff - y_ff : y_ff - y1_ff;
            sx_in    = (x_ff < x1_ff);
            sy_in    = (y_ff < y1_ff);
            if (dx_in > dy_in) begin
               err_in = $signed(ERR_W'(dx_in >> 1));
            end else begin
               err_in = -$signed(ERR_W'(dy_in >> 1));
            end
            count_in = COUNT_W'(1);
            state_in = S_ADDR;
         end
         S_ADDR: begin
            in_grid_in = (32'(x_ff) < GRID_W) && (32'(y_ff) < GRID_H);
            addr_in    = ADDR_W'(y_ff) * ADDR_W'(GRID_W) + ADDR_W'(x_ff);
            mem_re     = in_grid_in;
            state_in   = S_LVL;
         end
         S_LVL: begin
            if (op_read_ff) begin
               // read beat: report the stored words, zero outside the grid
               rsp_strobe_in = 1'b1;
               rsp_level_in  = in_grid_ff ? OUT_WORD_W'(rd_level) : '0;
               rsp_odds_in   = in_grid_ff ? OUT_WORD_W'(rd_odds) : '0;
               rsp_count_in  = '0;
               state_in      = S_IDLE;
            end else begin
               if (is_end) begin
                  upd_in       = 1'b1;
                  level_new_in = alu_le ? alu_wrap : rd_level;
               end else begin
                  upd_in       = alu_ge;
                  level_new_in = alu_ge ? alu_sat : rd_level;
               end
               state_in = S_ODD;
            end
         end
         S_ODD: begin
            mem_we    = in_grid_ff;
            mem_wdata = {level_new_ff, upd_ff ? alu_sat : rd_odds};
            if (is_end) begin
               rsp_strobe_in = 1'b1;
               rsp_level_in  = '0;
               rsp_odds_in   = '0;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end else begin
               // advance to the next cell of the line
               if (step_x) begin
                  x_in = sx_ff ? x_ff + COORD_W'(1) : x_ff - COORD_W'(1);
               end
               if (step_y) begin
                  y_in = sy_ff ? y_ff + COORD_W'(1) : y_ff - COORD_W'(1);
               end
               err_in   = err_ff - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
               count_in = count_ff + COUNT_W'(1);
               state_in = S_ADDR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clear_cnt_ff     <= '0;
         rsp_strobe_ff    <= 1'b0;
         free_step_ff     <= FREE_STEP_RESET;
         occupied_step_ff <= OCCUPIED_STEP_RESET;
         level_min_ff     <= LEVEL_MIN_RESET;
         level_max_ff     <= LEVEL_MAX_RESET;
      end else begin
         state_ff         <= state_in;
         clear_cnt_ff     <= clear_cnt_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         free_step_ff     <= free_step_in;
         occupied_step_ff <= occupied_step_in;
         level_min_ff     <= level_min_in;
         level_max_ff     <= level_max_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_read_ff   <= op_read_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      err_ff       <= err_in;
      count_ff     <= count_in;
      addr_ff      <= addr_in;
      in_grid_ff   <= in_grid_in;
      upd_ff       <= upd_in;
      level_new_ff <= level_new_in;
      rsp_level_ff <= rsp_level_in;
      rsp_odds_ff  <= rsp_odds_in;
      rsp_count_ff <= rsp_count_in;
   end

   // grid memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= grid_mem[addr_in];
      end
   end

endmodule
